@@ hw/rtl/pidc_pkg.sv @@
package pidc_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int DT_FRAC   = 16;
    localparam int BOUND_W   = 31;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int CFG_IDX_W = 8;
    localparam int STEP_W    = 4;
    localparam int LAST_STEP = 14;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t UNITY    = word_t'(1) <<< FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP   = 8'd0,
        REG_KI   = 8'd1,
        REG_KD   = 8'd2,
        REG_NCO  = 8'd3,
        REG_WP   = 8'd4,
        REG_WD   = 8'd5,
        REG_IBND = 8'd6,
        REG_OBND = 8'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OPND_ZERO  = 5'd0,
        OPND_MEAS  = 5'd1,
        OPND_TGT   = 5'd2,
        OPND_DT    = 5'd3,
        OPND_Q     = 5'd4,
        OPND_KP    = 5'd5,
        OPND_KI    = 5'd6,
        OPND_KD    = 5'd7,
        OPND_NCO   = 5'd8,
        OPND_WP    = 5'd9,
        OPND_WD    = 5'd10,
        OPND_IBND  = 5'd11,
        OPND_OBND  = 5'd12,
        OPND_ERRP  = 5'd13,
        OPND_ERRI  = 5'd14,
        OPND_ERRD  = 5'd15,
        OPND_KDT   = 5'd16,
        OPND_POUT  = 5'd17,
        OPND_TMP   = 5'd18,
        OPND_ACC   = 5'd19,
        OPND_FILT  = 5'd20,
        OPND_DOUT  = 5'd21,
        OPND_TOTAL = 5'd22
    } opnd_t;

    localparam int OPND_COUNT = 23;

    typedef enum logic [1:0] {
        ALU_PASS  = 2'd0,
        ALU_ADD   = 2'd1,
        ALU_SUB   = 2'd2,
        ALU_CLAMP = 2'd3
    } alu_op_t;

    typedef enum logic [3:0] {
        DST_NONE  = 4'd0,
        DST_ERRP  = 4'd1,
        DST_ERRI  = 4'd2,
        DST_ERRD  = 4'd3,
        DST_KDT   = 4'd4,
        DST_POUT  = 4'd5,
        DST_TMP   = 4'd6,
        DST_ACC   = 4'd7,
        DST_DOUT  = 4'd8,
        DST_TOTAL = 4'd9,
        DST_FILT  = 4'd10,
        DST_OUT   = 4'd11
    } dst_t;

    typedef struct packed {
        logic    mul_go;
        logic    mul_dt;
        opnd_t   mul_a;
        opnd_t   mul_b;
        alu_op_t alu_op;
        opnd_t   alu_a;
        opnd_t   alu_b;
        dst_t    dst;
        logic    out_load;
    } ctrl_t;

endpackage

@@ hw/rtl/pidc_mul.sv @@
module pidc_mul (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            go,
    input  logic            dt_shift,
    input  pidc_pkg::word_t a,
    input  pidc_pkg::word_t b,
    output pidc_pkg::word_t q
);
    import pidc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] shifted;
    logic                     dt_reg;
    logic                     vld_reg;
    word_t                    q_reg;
    word_t                    q_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    // floor shift of the full product, then saturate to the word
    always_comb begin
        shifted = dt_reg ? (prod_reg >>> DT_FRAC) : (prod_reg >>> FRAC_BITS);
        if (shifted[PROD_W-1:WORD_W-1] == '0 || shifted[PROD_W-1:WORD_W-1] == '1) begin
            q_next = shifted[WORD_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            q_next = WORD_MIN;
        end else begin
            q_next = WORD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= go;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            prod_reg <= prod_next;
            dt_reg   <= dt_shift;
        end
        if (vld_reg) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ hw/rtl/pidc_alu.sv @@
module pidc_alu (
    input  pidc_pkg::alu_op_t op,
    input  pidc_pkg::word_t   a,
    input  pidc_pkg::word_t   b,
    output pidc_pkg::word_t   y,
    output logic              hit
);
    import pidc_pkg::*;

    logic signed [WORD_W:0] sum;
    word_t                  neg_b;

    assign neg_b = -b;

    always_comb begin
        sum = '0;
        y   = a;
        hit = 1'b0;
        case (op)
            ALU_PASS: begin
                y = a;
            end
            ALU_ADD, ALU_SUB: begin
                if (op == ALU_ADD) begin
                    sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
                end else begin
                    sum = {a[WORD_W-1], a} - {b[WORD_W-1], b};
                end
                if (sum[WORD_W] != sum[WORD_W-1]) begin
                    y = sum[WORD_W] ? WORD_MIN : WORD_MAX;
                end else begin
                    y = sum[WORD_W-1:0];
                end
            end
            ALU_CLAMP: begin
                // b carries a nonnegative bound
                if (a > b) begin
                    y   = b;
                    hit = 1'b1;
                end else if (a < neg_b) begin
                    y   = neg_b;
                    hit = 1'b1;
                end
            end
            default: begin
                y = a;
            end
        endcase
    end

endmodule

@@ hw/rtl/pidc_seq.sv @@
module pidc_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_fire,
    input  logic            out_free,
    output logic            idle,
    output pidc_pkg::ctrl_t ctrl
);
    import pidc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                last_step;

    assign last_step = (step_reg == STEP_W'(LAST_STEP));
    assign idle      = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (!last_step) begin
                    step_next = step_reg + 1'b1;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // one step of the control law per cycle, the last step holding until the output is free;
    // multiplier results reach OPND_Q via the product and result registers, then hold until the next result
    always_comb begin
        ctrl = '0;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                4'd0: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_WP; ctrl.mul_b = OPND_TGT;
                    ctrl.alu_op = ALU_SUB; ctrl.alu_a = OPND_TGT; ctrl.alu_b = OPND_MEAS;
                    ctrl.dst    = DST_ERRI;
                end
                4'd1: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_WD; ctrl.mul_b = OPND_TGT;
                end
                4'd2: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_dt = 1'b1;
                    ctrl.mul_a  = OPND_KI; ctrl.mul_b = OPND_DT;
                    ctrl.alu_op = ALU_SUB; ctrl.alu_a = OPND_Q; ctrl.alu_b = OPND_MEAS;
                    ctrl.dst    = DST_ERRP;
                end
                4'd3: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_KP; ctrl.mul_b = OPND_ERRP;
                    ctrl.alu_op = ALU_SUB; ctrl.alu_a = OPND_Q; ctrl.alu_b = OPND_MEAS;
                    ctrl.dst    = DST_ERRD;
                end
                4'd4: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_KD; ctrl.mul_b = OPND_ERRD;
                    ctrl.alu_op = ALU_PASS; ctrl.alu_a = OPND_Q;
                    ctrl.dst    = DST_KDT;
                end
                4'd5: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_KDT; ctrl.mul_b = OPND_ERRI;
                    ctrl.alu_op = ALU_PASS; ctrl.alu_a = OPND_Q;
                    ctrl.dst    = DST_POUT;
                end
                4'd6: begin
                    ctrl.alu_op = ALU_SUB; ctrl.alu_a = OPND_Q; ctrl.alu_b = OPND_FILT;
                    ctrl.dst    = DST_TMP;
                end
                4'd7: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_a = OPND_NCO; ctrl.mul_b = OPND_TMP;
                end
                4'd8: begin
                    ctrl.alu_op = ALU_ADD; ctrl.alu_a = OPND_ACC; ctrl.alu_b = OPND_Q;
                    ctrl.dst    = DST_TMP;
                end
                4'd9: begin
                    ctrl.alu_op = ALU_CLAMP; ctrl.alu_a = OPND_TMP; ctrl.alu_b = OPND_IBND;
                    ctrl.dst    = DST_ACC;
                end
                4'd10: begin
                    ctrl.alu_op = ALU_PASS; ctrl.alu_a = OPND_Q;
                    ctrl.dst    = DST_DOUT;
                end
                4'd11: begin
                    ctrl.mul_go = 1'b1; ctrl.mul_dt = 1'b1;
                    ctrl.mul_a  = OPND_DOUT; ctrl.mul_b = OPND_DT;
                    ctrl.alu_op = ALU_ADD; ctrl.alu_a = OPND_POUT; ctrl.alu_b = OPND_ACC;
                    ctrl.dst    = DST_TOTAL;
                end
                4'd12: begin
                    ctrl.alu_op = ALU_ADD; ctrl.alu_a = OPND_TOTAL; ctrl.alu_b = OPND_DOUT;
                    ctrl.dst    = DST_TOTAL;
                end
                4'd13: begin
                    ctrl.alu_op = ALU_ADD; ctrl.alu_a = OPND_FILT; ctrl.alu_b = OPND_Q;
                    ctrl.dst    = DST_FILT;
                end
                4'd14: begin
                    ctrl.alu_op   = ALU_CLAMP; ctrl.alu_a = OPND_TOTAL; ctrl.alu_b = OPND_OBND;
                    ctrl.dst      = DST_OUT;
                    ctrl.out_load = out_free;
                end
                default: begin
                    ctrl = '0;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/pid_two_dof_controller.sv @@
// Channel  | Dir | Handshake               | Payload
// s_       | in  | s_tvalid / s_tready     | s_tdata: measured, target, step_time
// m_       | out | m_tvalid / m_tready     | m_tdata: four terms; m_tuser: clamp flags
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each item is accepted while idle, then runs 15 sequencer steps through the
// single shared multiplier (two-stage: product, then shift and saturate) and the
// shared saturating adder / clamp unit. The multiplier latency sets the order.
// Reset is synchronous, active low; it clears the integrator, the derivative
// filter, the gains (weights to 1.0) and both bounds.
// A result waits in the output register; the next item is accepted meanwhile and
// only its last step holds until the output register is free.
module pid_two_dof_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    // measured [31:0], target [63:32], step_time [79:64]
    input  logic [79:0]                      s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // drive [31:0], prop_term [63:32], integ_term [95:64], deriv_term [127:96]
    output logic [127:0]                     m_tdata,
    // drive_clamped [0], integ_clamped [1]
    output logic [1:0]                       m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidc_pkg::WORD_W-1:0]      cfg_data
);
    import pidc_pkg::*;

    // configuration
    word_t              kp_reg, ki_reg, kd_reg, nco_reg, wp_reg, wd_reg;
    logic [BOUND_W-1:0] ibnd_reg, obnd_reg;

    // sample and working values
    word_t              meas_reg, tgt_reg;
    logic [DT_W-1:0]    dt_reg;
    word_t              errp_reg, erri_reg, errd_reg, kdt_reg, pout_reg;
    word_t              tmp_reg, dout_reg, total_reg;
    word_t              acc_reg, filt_reg;
    logic               ihit_reg;

    // output register
    logic [127:0]       out_data_reg;
    logic [1:0]         out_user_reg;
    logic               out_vld_reg;

    logic               s_fire;
    logic               cfg_fire;
    logic               out_free;
    logic               idle;
    ctrl_t              ctrl;
    word_t              opnd_bus [OPND_COUNT];
    word_t              mul_q;
    word_t              alu_y;
    logic               alu_hit;

    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_vld_reg || m_tready;
    assign s_tready  = idle;

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tvalid = out_vld_reg;

    // operand selection shared by the multiplier and the adder
    assign opnd_bus[OPND_ZERO]  = '0;
    assign opnd_bus[OPND_MEAS]  = meas_reg;
    assign opnd_bus[OPND_TGT]   = tgt_reg;
    assign opnd_bus[OPND_DT]    = {{(WORD_W-DT_W){1'b0}}, dt_reg};
    assign opnd_bus[OPND_Q]     = mul_q;
    assign opnd_bus[OPND_KP]    = kp_reg;
    assign opnd_bus[OPND_KI]    = ki_reg;
    assign opnd_bus[OPND_KD]    = kd_reg;
    assign opnd_bus[OPND_NCO]   = nco_reg;
    assign opnd_bus[OPND_WP]    = wp_reg;
    assign opnd_bus[OPND_WD]    = wd_reg;
    assign opnd_bus[OPND_IBND]  = {{(WORD_W-BOUND_W){1'b0}}, ibnd_reg};
    assign opnd_bus[OPND_OBND]  = {{(WORD_W-BOUND_W){1'b0}}, obnd_reg};
    assign opnd_bus[OPND_ERRP]  = errp_reg;
    assign opnd_bus[OPND_ERRI]  = erri_reg;
    assign opnd_bus[OPND_ERRD]  = errd_reg;
    assign opnd_bus[OPND_KDT]   = kdt_reg;
    assign opnd_bus[OPND_POUT]  = pout_reg;
    assign opnd_bus[OPND_TMP]   = tmp_reg;
    assign opnd_bus[OPND_ACC]   = acc_reg;
    assign opnd_bus[OPND_FILT]  = filt_reg;
    assign opnd_bus[OPND_DOUT]  = dout_reg;
    assign opnd_bus[OPND_TOTAL] = total_reg;

    pidc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    pidc_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (ctrl.mul_go),
        .dt_shift (ctrl.mul_dt),
        .a        (opnd_bus[ctrl.mul_a]),
        .b        (opnd_bus[ctrl.mul_b]),
        .q        (mul_q)
    );

    pidc_alu u_alu (
        .op  (ctrl.alu_op),
        .a   (opnd_bus[ctrl.alu_a]),
        .b   (opnd_bus[ctrl.alu_b]),
        .y   (alu_y),
        .hit (alu_hit)
    );

    // register writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            nco_reg  <= '0;
            wp_reg   <= UNITY;
            wd_reg   <= UNITY;
            ibnd_reg <= '0;
            obnd_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_KP:   kp_reg   <= cfg_data;
                REG_KI:   ki_reg   <= cfg_data;
                REG_KD:   kd_reg   <= cfg_data;
                REG_NCO:  nco_reg  <= cfg_data;
                REG_WP:   wp_reg   <= cfg_data;
                REG_WD:   wd_reg   <= cfg_data;
                REG_IBND: ibnd_reg <= cfg_data[BOUND_W-1:0];
                REG_OBND: obnd_reg <= cfg_data[BOUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller state carried from one sample to the next
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            filt_reg <= '0;
        end else begin
            if (ctrl.dst == DST_ACC) begin
                acc_reg <= alu_y;
            end
            if (ctrl.dst == DST_FILT) begin
                filt_reg <= alu_y;
            end
        end
    end

    // capture the sample and write back the working values
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            meas_reg <= s_tdata[31:0];
            tgt_reg  <= s_tdata[63:32];
            dt_reg   <= s_tdata[79:64];
        end
        case (ctrl.dst)
            DST_ERRP:  errp_reg  <= alu_y;
            DST_ERRI:  erri_reg  <= alu_y;
            DST_ERRD:  errd_reg  <= alu_y;
            DST_KDT:   kdt_reg   <= alu_y;
            DST_POUT:  pout_reg  <= alu_y;
            DST_TMP:   tmp_reg   <= alu_y;
            DST_ACC:   ihit_reg  <= alu_hit;
            DST_DOUT:  dout_reg  <= alu_y;
            DST_TOTAL: total_reg <= alu_y;
            default: begin
            end
        endcase
        if (ctrl.out_load) begin
            out_data_reg <= {dout_reg, acc_reg, pout_reg, alu_y};
            out_user_reg <= {ihit_reg, alu_hit};
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

endmodule

@@ tb/sv/pid_two_dof_controller_test.sv @@
`timescale 1ns / 100ps

module pid_two_dof_controller_test;

    import pidc_pkg::*;

    // Run length and pacing
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 20;   // longer than one sample takes to pass through the block
    localparam int RANDOM_PHASES   = 11;
    localparam int PHASE_ITEMS     = 50;
    localparam int HOLD_AFTER      = 100;  // results seen before the long back-pressure stretch
    localparam int LONG_HOLD       = 300;
    localparam int MAX_PRINTED     = 40;

    // Register index just past the last defined one; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd8;

    // Directed gain settings
    localparam int S_RESET = 0;
    localparam int S_PONLY = 1;
    localparam int S_UNITY = 2;
    localparam int S_HIGH  = 3;
    localparam int S_LOW   = 4;
    localparam int S_MID   = 5;
    localparam int S_EQUAL = 6;
    localparam int SETTING_COUNT = 7;
    localparam int DIR_ROWS = 23;

    // One controller result as it leaves the block
    typedef struct packed {
        word_t drive;
        word_t prop;
        word_t integ;
        word_t deriv;
        logic  drive_hit;
        logic  integ_hit;
    } result_t;

    // Full register image of the controller
    typedef struct packed {
        word_t       kp;
        word_t       ki;
        word_t       kd;
        word_t       nco;
        word_t       wp;
        word_t       wd;
        logic [31:0] ibnd;
        logic [31:0] obnd;
    } setting_t;

    // One directed sample; typed rows carry their result, the rest use the predictor
    typedef struct packed {
        int          setting;
        word_t       meas;
        word_t       tgt;
        logic [15:0] dt;
        logic        typed;
        result_t     want;
    } drow_t;

    localparam result_t NO_RESULT = '0;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [79:0]          s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [127:0]         m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    pid_two_dof_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Predictor copy of the registers and of the loop state
    word_t              cfg_kp, cfg_ki, cfg_kd, cfg_nco, cfg_wp, cfg_wd;
    logic [BOUND_W-1:0] cfg_ibnd, cfg_obnd;
    word_t              ctl_integral, ctl_filter;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      cycle_count    = 0;
    bit      calm           = 1'b0;  // final stretch: no idling on either side

    setting_t settings [SETTING_COUNT] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, UNITY, UNITY, 32'h0, 32'h0},
        '{UNITY, 32'sd0, 32'sd0, 32'sd0, UNITY, UNITY, 32'h0, 32'h0},
        '{UNITY, UNITY, UNITY, UNITY, UNITY, UNITY, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
        '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 32'h8000_0000, 32'h0},
        '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX,
          32'h7FFF_FFFF, 32'hFFFF_FFFF},
        '{32'sh0002_8000, 32'sh000A_0000, 32'sh0000_8000, 32'sh0014_0000,
          32'sh0000_C000, 32'sd0, 32'h0003_0000, 32'h0005_0000},
        '{UNITY, 32'sd0, 32'sd0, 32'sd0, UNITY, UNITY, 32'h0, UNITY}
    };

    drow_t dir_rows [DIR_ROWS] = '{
        // After reset the weights are 1.0 and every other gain and bound is zero, so everything reads zero
        '{S_RESET, 32'sd0, 32'sd0, 16'h0000, 1'b1, NO_RESULT},
        '{S_RESET, WORD_MIN, WORD_MAX, 16'hFFFF, 1'b1, NO_RESULT},
        '{S_RESET, WORD_MAX, WORD_MIN, 16'h0000, 1'b1, NO_RESULT},
        // Zero output bound forces the drive to zero and flags it
        '{S_PONLY, 32'sd0, UNITY, 16'h0000, 1'b1,
          '{32'sd0, UNITY, 32'sd0, 32'sd0, 1'b1, 1'b0}},
        '{S_PONLY, UNITY, 32'sd0, 16'h0000, 1'b1,
          '{32'sd0, -UNITY, 32'sd0, 32'sd0, 1'b1, 1'b0}},
        // Drive equal to the bound passes unflagged; one LSB beyond clamps
        '{S_EQUAL, 32'sd0, UNITY, 16'h0000, 1'b1,
          '{UNITY, UNITY, 32'sd0, 32'sd0, 1'b0, 1'b0}},
        '{S_EQUAL, 32'sd0, UNITY + 32'sd1, 16'h0000, 1'b1,
          '{UNITY, UNITY + 32'sd1, 32'sd0, 32'sd0, 1'b1, 1'b0}},
        '{S_EQUAL, UNITY, 32'sd0, 16'h0000, 1'b1,
          '{-UNITY, -UNITY, 32'sd0, 32'sd0, 1'b0, 1'b0}},
        '{S_UNITY, 32'sd0, UNITY, 16'h8000, 1'b0, NO_RESULT},
        '{S_UNITY, 32'sd0, UNITY, 16'h8000, 1'b0, NO_RESULT},
        '{S_UNITY, 32'sh0003_0000, -UNITY, 16'hFFFF, 1'b0, NO_RESULT},
        '{S_UNITY, WORD_MAX, WORD_MIN, 16'hFFFF, 1'b0, NO_RESULT},
        '{S_UNITY, WORD_MIN, WORD_MAX, 16'hFFFF, 1'b0, NO_RESULT},
        '{S_UNITY, 32'sd0, 32'sd0, 16'h0001, 1'b0, NO_RESULT},
        '{S_HIGH, WORD_MIN, WORD_MAX, 16'hFFFF, 1'b0, NO_RESULT},
        '{S_HIGH, WORD_MAX, WORD_MAX, 16'h1234, 1'b0, NO_RESULT},
        '{S_HIGH, -32'sd1, 32'sd1, 16'h0001, 1'b0, NO_RESULT},
        '{S_LOW, WORD_MAX, WORD_MIN, 16'hFFFF, 1'b0, NO_RESULT},
        '{S_LOW, 32'sd12345, -32'sd6789, 16'h0100, 1'b0, NO_RESULT},
        '{S_LOW, 32'sd0, 32'sd0, 16'h0000, 1'b0, NO_RESULT},
        '{S_MID, 32'sh0000_8000, UNITY, 16'h0148, 1'b0, NO_RESULT},
        '{S_MID, 32'sh0000_C000, UNITY, 16'h0148, 1'b0, NO_RESULT},
        '{S_MID, -32'sh0002_0000, 32'sh0001_8000, 16'h0400, 1'b0, NO_RESULT}
    };

    // ---------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------

    // Saturate a wide value to the signed word
    function automatic longint sat_word(longint v);
        if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
        if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
        return v;
    endfunction

    // Full product, floor shift, saturate; both factors fit in a word
    function automatic longint qmul(longint a, longint b, int sh);
        longint p;
        p = a * b;
        return sat_word(p >>> sh);
    endfunction

    function automatic longint clamp_mag(longint v, longint bound, output bit hit);
        hit = 1'b0;
        if (v > bound) begin
            hit = 1'b1;
            return bound;
        end
        if (v < -bound) begin
            hit = 1'b1;
            return -bound;
        end
        return v;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        case (index)
            REG_KP:   cfg_kp   = data;
            REG_KI:   cfg_ki   = data;
            REG_KD:   cfg_kd   = data;
            REG_NCO:  cfg_nco  = data;
            REG_WP:   cfg_wp   = data;
            REG_WD:   cfg_wd   = data;
            REG_IBND: cfg_ibnd = data[BOUND_W-1:0];
            REG_OBND: cfg_obnd = data[BOUND_W-1:0];
            default: ;
        endcase
    endfunction

    // Work out one control sample and advance the integrator and filter
    function automatic result_t predict_control(word_t meas, word_t tgt, logic [15:0] dt);
        longint  m, t, d, err_p, err_i, err_d, pout, inc, acc, dout, total;
        bit      ihit, ohit;
        result_t r;
        m = meas;
        t = tgt;
        d = longint'(dt);
        err_p = sat_word(qmul(cfg_wp, t, FRAC_BITS) - m);
        err_i = sat_word(t - m);
        err_d = sat_word(qmul(cfg_wd, t, FRAC_BITS) - m);
        pout  = qmul(cfg_kp, err_p, FRAC_BITS);
        inc   = qmul(qmul(cfg_ki, d, DT_FRAC), err_i, FRAC_BITS);
        acc   = clamp_mag(sat_word(longint'(ctl_integral) + inc), longint'(cfg_ibnd), ihit);
        dout  = qmul(cfg_nco, sat_word(qmul(cfg_kd, err_d, FRAC_BITS) - ctl_filter),
                     FRAC_BITS);
        ctl_integral = word_t'(acc);
        ctl_filter   = word_t'(sat_word(longint'(ctl_filter) + qmul(dout, d, DT_FRAC)));
        total = clamp_mag(sat_word(sat_word(pout + acc) + dout), longint'(cfg_obnd), ohit);
        r.drive     = word_t'(total);
        r.prop      = word_t'(pout);
        r.integ     = word_t'(acc);
        r.deriv     = word_t'(dout);
        r.drive_hit = ohit;
        r.integ_hit = ihit;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random values
    // ---------------------------------------------------------------

    function automatic word_t rand_gain();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return UNITY;
            4, 5, 6: return word_t'($urandom_range(0, 1 << 19) - (1 << 18));  // +/- 4.0
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t rand_sample();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -32'sd1;
            4, 5, 6: return word_t'($urandom_range(0, 1 << 20) - (1 << 19));  // +/- 8.0
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 16'h0400));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Compare one accepted result against the oldest expectation, field by field
    task automatic check_result();
        result_t got, want;
        got.drive     = m_tdata[31:0];
        got.prop      = m_tdata[63:32];
        got.integ     = m_tdata[95:64];
        got.deriv     = m_tdata[127:96];
        got.drive_hit = m_tuser[0];
        got.integ_hit = m_tuser[1];
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, drive %h", got.drive));
            return;
        end
        want = pending_results.pop_front();
        if (got.drive !== want.drive)
            report_mismatch($sformatf("drive %h, expected %h", got.drive, want.drive));
        if (got.prop !== want.prop)
            report_mismatch($sformatf("prop_term %h, expected %h", got.prop, want.prop));
        if (got.integ !== want.integ)
            report_mismatch($sformatf("integ_term %h, expected %h", got.integ, want.integ));
        if (got.deriv !== want.deriv)
            report_mismatch($sformatf("deriv_term %h, expected %h", got.deriv, want.deriv));
        if (got.drive_hit !== want.drive_hit)
            report_mismatch($sformatf("drive_clamped %b, expected %b",
                                      got.drive_hit, want.drive_hit));
        if (got.integ_hit !== want.integ_hit)
            report_mismatch($sformatf("integ_clamped %b, expected %b",
                                      got.integ_hit, want.integ_hit));
    endtask

    // Sample the result channel on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            check_result();
    end

    // Cycle counter; stop the run if the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random ready/stall bursts, one long hold-off, then always ready
    // ---------------------------------------------------------------

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (calm) begin
                m_tready = 1'b1;
                @(negedge aclk);
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // Hold off long enough for the block to fill and stall its input
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side; every task starts and ends on a falling edge
    // ---------------------------------------------------------------

    task automatic idle_burst();
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge aclk);
    endtask

    // Offer one sample, hold it until accepted, then queue its expected result
    task automatic send_sample(word_t meas, word_t tgt, logic [15:0] dt,
                               logic typed, result_t typed_want);
        result_t r;
        s_tdata  = {dt, tgt, meas};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        // Always run the predictor so the integrator and filter stay in step
        r = predict_control(meas, tgt, dt);
        if (typed)
            r = typed_want;
        pending_results.push_back(r);
        @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drain every outstanding result, then let the sequencer settle
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Reprogram all registers while idle; finish with a write to an unused index
    task automatic load_setting(setting_t s);
        drain_results();
        write_register(REG_KP,   s.kp);
        write_register(REG_KI,   s.ki);
        write_register(REG_KD,   s.kd);
        write_register(REG_NCO,  s.nco);
        write_register(REG_WP,   s.wp);
        write_register(REG_WD,   s.wd);
        write_register(REG_IBND, s.ibnd);
        write_register(REG_OBND, s.obnd);
        write_register(REG_UNUSED + CFG_IDX_W'($urandom_range(0, 247)), $urandom);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int       cur_setting;
        setting_t s;

        // Mirror the reset state of the block
        apply_register(REG_KP, '0);
        apply_register(REG_KI, '0);
        apply_register(REG_KD, '0);
        apply_register(REG_NCO, '0);
        apply_register(REG_WP, UNITY);
        apply_register(REG_WD, UNITY);
        apply_register(REG_IBND, '0);
        apply_register(REG_OBND, '0);
        ctl_integral = '0;
        ctl_filter   = '0;

        // Hold reset, then release it on a falling edge
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table: reprogram only when a row asks for a new setting
        cur_setting = S_RESET;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].setting != cur_setting) begin
                cur_setting = dir_rows[i].setting;
                load_setting(settings[cur_setting]);
            end
            if ($urandom_range(0, 3) == 0)
                idle_burst();
            send_sample(dir_rows[i].meas, dir_rows[i].tgt, dir_rows[i].dt,
                        dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under its own random register image
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s.kp   = rand_gain();
            s.ki   = rand_gain();
            s.kd   = rand_gain();
            s.nco  = rand_gain();
            s.wp   = rand_gain();
            s.wd   = rand_gain();
            s.ibnd = rand_bound();
            s.obnd = rand_bound();
            load_setting(s);
            // Last phase runs flat out on both sides
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!calm && $urandom_range(0, 3) == 0)
                    idle_burst();
                send_sample(rand_sample(), rand_sample(), rand_step(), 1'b0, NO_RESULT);
            end
        end
        s_tvalid = 1'b0;

        // Wait for the last results, then a little longer for strays
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
